@@ hdl/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, codes and reset values of the partition cut counter.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int MAX_NODES_DEF = 4096;
  localparam int MAX_PARTS_DEF = 8;

  localparam int IDX_W   = 16;
  localparam int PVAL_W  = 5;
  localparam int PART_W  = 3;
  localparam int NP_W    = 4;
  localparam int NC_W    = 13;
  localparam int ADJ_W   = 64;
  localparam int CNT_W   = 32;
  localparam int CFG_A_W = 2;

  localparam logic [NP_W-1:0]  NUM_PARTS_RST  = 4'd2;
  localparam logic [NC_W-1:0]  NODE_COUNT_RST = 13'd4096;
  localparam logic [ADJ_W-1:0] ADJ_MAP_RST    = {ADJ_W{1'b1}};

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_PIN   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_NUM_PARTS  = 2'd0,
    CFG_NODE_COUNT = 2'd1,
    CFG_ADJ_MAP    = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t  op;
    logic first;
    logic in_range;
  } pin_t;

endpackage

@@ hdl/partition_cut_and_violation_counter.sv @@
// ----------------------------------------------------------------------------
// partition_cut_and_violation_counter
// K-way partition cut and topology violation counter, first-pin star model.
// ----------------------------------------------------------------------------
// Input stream: tuser carries op and first_pin, tdata carries node index and
// part value. Op 0 loads a partition table entry, op 1 is a net pin (first_pin
// marks the anchor), op 2 zeroes the counters. Every input beat yields one
// output beat holding the cut and violation counters after that beat.
// The table is read into the read stage at the accept edge, and the score
// updates into the output register when that stage advances.
// Throughput is one beat per cycle without stalls; the single table read port sets this.
// A stalled output holds its beat; one more item waits in the read stage and
// in_tready drops only while both are full.
// Reset clears the counters, anchor and pipeline valid flags and loads the
// register defaults (num_parts 2, node_count 4096, all parts adjacent). The
// table is not cleared; write an entry before a pin reads it.
// Configuration writes take effect on the next clock edge.
// ----------------------------------------------------------------------------
module partition_cut_and_violation_counter #(
  parameter int MAX_NODES = ptc_pkg::MAX_NODES_DEF,
  parameter int MAX_PARTS = ptc_pkg::MAX_PARTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // node_index[15:0], part_value[20:16]
  input  logic [2:0]                    in_tuser,   // op[1:0], first_pin[2]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata,  // cut_count[31:0], violation_count[63:32]
  input  logic                          cfg_we,
  input  logic [ptc_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [ptc_pkg::ADJ_W-1:0]     cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_NODES);

  logic [ptc_pkg::NP_W-1:0]   num_parts_r;
  logic [ptc_pkg::NC_W-1:0]   node_count_r;
  logic [ptc_pkg::ADJ_W-1:0]  adj_map_r;

  logic [ptc_pkg::IDX_W-1:0]  in_idx;
  logic [ptc_pkg::PVAL_W-1:0] in_pval;
  ptc_pkg::op_t               in_op;
  logic                       in_first;
  logic                       in_acc;
  logic                       idx_in_mem;
  logic                       idx_in_cnt;

  ptc_pkg::pin_t              s1_pin_r, s1_pin_nxt;
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_free;
  logic                       adv;
  logic [ptc_pkg::PVAL_W-1:0] rdata;
  logic [ptc_pkg::CNT_W-1:0]  cut_count;
  logic [ptc_pkg::CNT_W-1:0]  violation_count;

  assign in_idx   = in_tdata[15:0];
  assign in_pval  = in_tdata[20:16];
  assign in_op    = ptc_pkg::op_t'(in_tuser[1:0]);
  assign in_first = in_tuser[2];

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign idx_in_mem = ({1'b0, in_idx} < 17'(MAX_NODES));
  assign idx_in_cnt = ({3'b000, node_count_r} > in_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_parts_r  <= ptc_pkg::NUM_PARTS_RST;
      node_count_r <= ptc_pkg::NODE_COUNT_RST;
      adj_map_r    <= ptc_pkg::ADJ_MAP_RST;
    end else if (cfg_we) begin
      case (ptc_pkg::cfg_idx_t'(cfg_addr))
        ptc_pkg::CFG_NUM_PARTS:  num_parts_r  <= cfg_wdata[ptc_pkg::NP_W-1:0];
        ptc_pkg::CFG_NODE_COUNT: node_count_r <= cfg_wdata[ptc_pkg::NC_W-1:0];
        ptc_pkg::CFG_ADJ_MAP:    adj_map_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ptc_table #(
    .DEPTH  (MAX_NODES),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (in_acc && (in_op == ptc_pkg::OP_WRITE) && idx_in_mem),
    .waddr (in_idx[ADDR_W-1:0]),
    .wdata (in_pval),
    .re    (in_acc && (in_op == ptc_pkg::OP_PIN) && idx_in_mem),
    .raddr (in_idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_pin_nxt   = s1_pin_r;
    if (in_acc) begin
      s1_valid_nxt      = 1'b1;
      s1_pin_nxt.op     = in_op;
      s1_pin_nxt.first  = in_first;
      s1_pin_nxt.in_range = idx_in_mem && idx_in_cnt;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pin_r <= s1_pin_nxt;
  end

  ptc_score #(
    .MAX_PARTS (MAX_PARTS)
  ) u_score (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .pin             (s1_pin_r),
    .rdata           (rdata),
    .num_parts       (num_parts_r),
    .adj_map         (adj_map_r),
    .cut_count       (cut_count),
    .violation_count (violation_count)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {violation_count, cut_count};

`ifndef ASSERT_OFF
  a_viol_le_cut: assert property (@(posedge clk) disable iff (!rst_n)
    violation_count <= cut_count)
    else $error("violation count exceeds cut count");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled with free pipeline space");

  a_hold_counts: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(cut_count) && $stable(violation_count)))
    else $error("counters changed without an advancing beat");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (s1_pin_r.op == ptc_pkg::OP_CLEAR)) |=>
      ((cut_count == '0) && (violation_count == '0) && out_tvalid))
    else $error("clear beat did not zero the counters");
`endif

endmodule

@@ hdl/ptc_table.sv @@
// ----------------------------------------------------------------------------
// ptc_table
// Partition table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ptc_table #(
  parameter int DEPTH  = ptc_pkg::MAX_NODES_DEF,
  parameter int ADDR_W = $clog2(ptc_pkg::MAX_NODES_DEF)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [ptc_pkg::PVAL_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [ptc_pkg::PVAL_W-1:0] rdata
);

  logic [ptc_pkg::PVAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/ptc_score.sv @@
// ----------------------------------------------------------------------------
// ptc_score
// Anchor tracking and saturating cut / violation counters.
// ----------------------------------------------------------------------------
module ptc_score #(
  parameter int MAX_PARTS = ptc_pkg::MAX_PARTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  ptc_pkg::pin_t              pin,
  input  logic [ptc_pkg::PVAL_W-1:0] rdata,
  input  logic [ptc_pkg::NP_W-1:0]   num_parts,
  input  logic [ptc_pkg::ADJ_W-1:0]  adj_map,
  output logic [ptc_pkg::CNT_W-1:0]  cut_count,
  output logic [ptc_pkg::CNT_W-1:0]  violation_count
);

  logic [ptc_pkg::PART_W-1:0] anchor_part_r, anchor_part_nxt;
  logic                       anchor_valid_r, anchor_valid_nxt;
  logic [ptc_pkg::CNT_W-1:0]  cut_r, cut_nxt;
  logic [ptc_pkg::CNT_W-1:0]  viol_r, viol_nxt;
  logic [ptc_pkg::NP_W-1:0]   eff_parts;
  logic                       part_ok;
  logic [ptc_pkg::PART_W-1:0] part;
  logic [5:0]                 adj_bit;

  assign eff_parts = (num_parts > ptc_pkg::NP_W'(MAX_PARTS)) ?
                     ptc_pkg::NP_W'(MAX_PARTS) : num_parts;
  assign part      = rdata[ptc_pkg::PART_W-1:0];
  assign part_ok   = pin.in_range && !rdata[ptc_pkg::PVAL_W-1] &&
                     (rdata[ptc_pkg::NP_W-1:0] < eff_parts);
  assign adj_bit   = {anchor_part_r, part};

  always_comb begin
    anchor_part_nxt  = anchor_part_r;
    anchor_valid_nxt = anchor_valid_r;
    cut_nxt          = cut_r;
    viol_nxt         = viol_r;
    if (adv) begin
      case (pin.op)
        ptc_pkg::OP_PIN: begin
          if (pin.first) begin
            anchor_valid_nxt = part_ok;
            anchor_part_nxt  = part_ok ? part : '0;
          end else if (anchor_valid_r && part_ok && (part != anchor_part_r)) begin
            cut_nxt = (cut_r == '1) ? cut_r : cut_r + 1'b1;
            if (!adj_map[adj_bit]) begin
              viol_nxt = (viol_r == '1) ? viol_r : viol_r + 1'b1;
            end
          end
        end
        ptc_pkg::OP_CLEAR: begin
          cut_nxt  = '0;
          viol_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_part_r  <= '0;
      anchor_valid_r <= 1'b0;
      cut_r          <= '0;
      viol_r         <= '0;
    end else begin
      anchor_part_r  <= anchor_part_nxt;
      anchor_valid_r <= anchor_valid_nxt;
      cut_r          <= cut_nxt;
      viol_r         <= viol_nxt;
    end
  end

  assign cut_count       = cut_r;
  assign violation_count = viol_r;

endmodule

@@ sim/partition_cut_and_violation_counter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// partition_cut_and_violation_counter_tb
// Self-checking bench for the K-way partition cut and violation counter.
// ----------------------------------------------------------------------------
// A short table of directed beats covers the field extremes, every op and the
// corner cases: skipped nets, out-of-range writes and pins, invalid anchors,
// zero and oversized part and node limits, and a register change inside a
// net. Random traffic follows in phases. Each phase programs new registers
// while the block is idle and runs one of four idle/stall profiles. Loads,
// nets and noise are mixed. A scoring model in the bench predicts the two
// counters for every accepted input beat (typed directed rows queue their
// table values instead); each output beat is checked against the oldest entry.
// ----------------------------------------------------------------------------
module partition_cut_and_violation_counter_tb;

  localparam int ITEMS_PER_PHASE = 236;
  localparam int PHASE_COUNT     = 8;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 10;

  typedef struct packed {
    logic [ptc_pkg::CNT_W-1:0] cut;
    logic [ptc_pkg::CNT_W-1:0] viol;
  } counts_t;

  typedef struct packed {
    logic                      is_cfg;
    ptc_pkg::cfg_idx_t         reg_sel;
    logic [ptc_pkg::ADJ_W-1:0] reg_val;
    ptc_pkg::op_t              op;
    logic [15:0]               node;
    logic [4:0]                part;
    logic                      first;
    logic                      typed;
    logic [31:0]               cut;
    logic [31:0]               viol;
  } stim_row_t;

  localparam int NROW = 33;
  localparam stim_row_t PLAN [NROW] = '{
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'hFFFF, 5'h00, 1'b1,
      1'b1, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_WRITE, 16'd0, 5'h00, 1'b0,
      1'b1, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_WRITE, 16'd4095, 5'h01, 1'b0,
      1'b1, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_WRITE, 16'd1, 5'h1F, 1'b1,
      1'b1, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_WRITE, 16'd4096, 5'h01, 1'b0,
      1'b1, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_WRITE, 16'd2, 5'h0F, 1'b0,
      1'b1, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_WRITE, 16'd3, 5'h07, 1'b0,
      1'b1, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd0, 5'h1F, 1'b1,
      1'b1, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd4095, 5'h00, 1'b0,
      1'b1, 32'd1, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd1, 5'h00, 1'b0,
      1'b1, 32'd1, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd2, 5'h00, 1'b0,
      1'b1, 32'd1, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd0, 5'h00, 1'b0,
      1'b1, 32'd1, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'hFFFF, 5'h00, 1'b0,
      1'b1, 32'd1, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_NOP, 16'hFFFF, 5'h1F, 1'b1,
      1'b1, 32'd1, 32'd0},
    '{1'b1, ptc_pkg::CFG_ADJ_MAP, 64'd0, ptc_pkg::OP_NOP, 16'd0, 5'h00, 1'b0,
      1'b0, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd4095, 5'h00, 1'b0,
      1'b1, 32'd2, 32'd1},
    '{1'b1, ptc_pkg::CFG_NUM_PARTS, 64'd8, ptc_pkg::OP_NOP, 16'd0, 5'h00, 1'b0,
      1'b0, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd3, 5'h00, 1'b0,
      1'b1, 32'd3, 32'd2},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd1, 5'h00, 1'b1,
      1'b1, 32'd3, 32'd2},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd4095, 5'h00, 1'b0,
      1'b1, 32'd3, 32'd2},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_CLEAR, 16'd0, 5'h00, 1'b0,
      1'b1, 32'd0, 32'd0},
    '{1'b1, ptc_pkg::CFG_NUM_PARTS, 64'd0, ptc_pkg::OP_NOP, 16'd0, 5'h00, 1'b0,
      1'b0, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd0, 5'h00, 1'b1,
      1'b1, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd4095, 5'h00, 1'b0,
      1'b1, 32'd0, 32'd0},
    '{1'b1, ptc_pkg::CFG_NUM_PARTS, 64'd15, ptc_pkg::OP_NOP, 16'd0, 5'h00, 1'b0,
      1'b0, 32'd0, 32'd0},
    '{1'b1, ptc_pkg::CFG_NODE_COUNT, 64'd0, ptc_pkg::OP_NOP, 16'd0, 5'h00, 1'b0,
      1'b0, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd0, 5'h00, 1'b1,
      1'b1, 32'd0, 32'd0},
    '{1'b1, ptc_pkg::CFG_NODE_COUNT, 64'd8191, ptc_pkg::OP_NOP, 16'd0, 5'h00, 1'b0,
      1'b0, 32'd0, 32'd0},
    '{1'b1, ptc_pkg::CFG_ADJ_MAP, 64'hFDFF_FFFF_FFFF_FFFF, ptc_pkg::OP_NOP, 16'd0,
      5'h00, 1'b0, 1'b0, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd3, 5'h00, 1'b1,
      1'b0, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd4095, 5'h00, 1'b0,
      1'b0, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_PIN, 16'd0, 5'h00, 1'b0,
      1'b0, 32'd0, 32'd0},
    '{1'b0, ptc_pkg::CFG_UNUSED, 64'd0, ptc_pkg::OP_WRITE, 16'd3, 5'h10, 1'b0,
      1'b0, 32'd0, 32'd0}
  };

  logic                       clk;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [23:0]                in_tdata   = '0;  // node_index[15:0], part_value[20:16]
  logic [2:0]                 in_tuser   = '0;  // op[1:0], first_pin[2]
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [63:0]                out_tdata;        // cut_count[31:0], violation_count[63:32]
  logic                       cfg_we     = 1'b0;
  ptc_pkg::cfg_idx_t          cfg_addr   = ptc_pkg::CFG_NUM_PARTS;
  logic [ptc_pkg::ADJ_W-1:0]  cfg_wdata  = '0;

  // scoring model state
  logic [4:0]                 part_tbl [ptc_pkg::MAX_NODES_DEF];
  logic [3:0]                 anchor_part_q;
  bit                         anchor_ok;
  logic [ptc_pkg::CNT_W-1:0]  cut_cnt;
  logic [ptc_pkg::CNT_W-1:0]  viol_cnt;
  logic [ptc_pkg::NP_W-1:0]   k_reg;
  logic [ptc_pkg::NC_W-1:0]   nodes_reg;
  logic [ptc_pkg::ADJ_W-1:0]  adj_reg;

  counts_t                    tally_q [$];
  bit                         loaded_map [ptc_pkg::MAX_NODES_DEF];
  int                         loaded_nodes [$];
  int                         err_count;
  int                         stuck_cycles;
  int                         gap_pct;
  int                         stall_pct;
  int                         phase_items;
  bit                         drained_once;

  partition_cut_and_violation_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int parts_limit();
    return (int'(k_reg) > ptc_pkg::MAX_PARTS_DEF) ? ptc_pkg::MAX_PARTS_DEF : int'(k_reg);
  endfunction

  function automatic int nodes_limit();
    return (int'(nodes_reg) > ptc_pkg::MAX_NODES_DEF) ? ptc_pkg::MAX_NODES_DEF :
           int'(nodes_reg);
  endfunction

  // part of a node, or -1 when the node is out of range or its part invalid
  function automatic int node_part(logic [15:0] node);
    logic signed [4:0] raw;
    int                p;
    if (int'(node) >= nodes_limit()) return -1;
    raw = part_tbl[node[11:0]];
    p = raw;
    if (p < 0 || p >= parts_limit()) return -1;
    return p;
  endfunction

  function automatic counts_t score_beat(ptc_pkg::op_t op, logic [15:0] node,
                                         logic [4:0] part, logic first);
    int p;
    p = node_part(node);
    case (op)
      ptc_pkg::OP_WRITE: begin
        if (int'(node) < ptc_pkg::MAX_NODES_DEF) part_tbl[node[11:0]] = part;
      end
      ptc_pkg::OP_PIN: begin
        if (first) begin
          anchor_ok = (p >= 0);
          anchor_part_q = anchor_ok ? p[3:0] : 4'd0;
        end else if (anchor_ok && p >= 0 && p != int'(anchor_part_q)) begin
          if (cut_cnt != '1) cut_cnt = cut_cnt + 1;
          if (!adj_reg[6'(int'(anchor_part_q) * 8 + p)] && viol_cnt != '1)
            viol_cnt = viol_cnt + 1;
        end
      end
      ptc_pkg::OP_CLEAR: begin
        cut_cnt = '0;
        viol_cnt = '0;
      end
      default: ;
    endcase
    return '{cut: cut_cnt, viol: viol_cnt};
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic wait_drained();
    while (tally_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input ptc_pkg::cfg_idx_t sel,
                           input logic [ptc_pkg::ADJ_W-1:0] val);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    case (sel)
      ptc_pkg::CFG_NUM_PARTS:  k_reg = val[ptc_pkg::NP_W-1:0];
      ptc_pkg::CFG_NODE_COUNT: nodes_reg = val[ptc_pkg::NC_W-1:0];
      ptc_pkg::CFG_ADJ_MAP:    adj_reg = val;
      default: ;
    endcase
  endtask

  task automatic push_item(input ptc_pkg::op_t op, input logic [15:0] node,
                           input logic [4:0] part, input logic first, input bit typed,
                           input counts_t want);
    counts_t tally;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, part, node};
    in_tuser  <= {first, op};
    do @(posedge clk); while (!in_tready);
    tally = score_beat(op, node, part, first);
    tally_q.push_back(typed ? want : tally);
    if (op == ptc_pkg::OP_WRITE && int'(node) < ptc_pkg::MAX_NODES_DEF &&
        !loaded_map[node[11:0]]) begin
      loaded_map[node[11:0]] = 1'b1;
      loaded_nodes.push_back(int'(node));
    end
    phase_items++;
  endtask

  // pin node: a loaded entry, or one beyond the node_count or table range
  function automatic logic [15:0] pick_pin_node();
    int lim;
    lim = nodes_limit();
    if (loaded_nodes.size() > 0 && $urandom_range(99) < 85)
      return 16'(loaded_nodes[$urandom_range(loaded_nodes.size() - 1)]);
    if (lim < ptc_pkg::MAX_NODES_DEF && $urandom_range(1) == 1)
      return 16'($urandom_range(ptc_pkg::MAX_NODES_DEF - 1, lim));
    return 16'($urandom_range(65535, ptc_pkg::MAX_NODES_DEF));
  endfunction

  function automatic logic [15:0] pick_load_node();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 16'($urandom_range(255));
    if (r < 90) return 16'($urandom_range(ptc_pkg::MAX_NODES_DEF - 1));
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [4:0] pick_part();
    return ($urandom_range(99) < 75) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
  endfunction

  task automatic send_loads();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) push_item(ptc_pkg::OP_WRITE, pick_load_node(), pick_part(),
                         1'($urandom_range(1)), 1'b0, '0);
  endtask

  task automatic send_net();
    int n;
    push_item(ptc_pkg::OP_PIN, pick_pin_node(), 5'($urandom_range(31)), 1'b1, 1'b0, '0);
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(99) < 5)
        push_item(($urandom_range(3) == 0) ? ptc_pkg::OP_CLEAR : ptc_pkg::OP_WRITE,
                  pick_load_node(), pick_part(), 1'b0, 1'b0, '0);
      push_item(ptc_pkg::OP_PIN, pick_pin_node(), 5'($urandom_range(31)), 1'b0, 1'b0,
                '0);
    end
  endtask

  task automatic send_noise();
    ptc_pkg::op_t op;
    op = ptc_pkg::op_t'($urandom_range(3));
    push_item(op, (op == ptc_pkg::OP_PIN) ? pick_pin_node() : 16'($urandom_range(65535)),
              5'($urandom_range(31)), 1'($urandom_range(1)), 1'b0, '0);
  endtask

  task automatic program_phase(input int ph);
    case (ph)
      0: begin
        cfg_write(ptc_pkg::CFG_NUM_PARTS, 64'd8);
        cfg_write(ptc_pkg::CFG_NODE_COUNT, 64'd4096);
        cfg_write(ptc_pkg::CFG_ADJ_MAP, {$urandom, $urandom});
      end
      1: begin
        cfg_write(ptc_pkg::CFG_NUM_PARTS, 64'd1);
        cfg_write(ptc_pkg::CFG_ADJ_MAP, '1);
      end
      2: begin
        cfg_write(ptc_pkg::CFG_NUM_PARTS, 64'd15);
        cfg_write(ptc_pkg::CFG_NODE_COUNT, 64'($urandom_range(4096, 1)));
        cfg_write(ptc_pkg::CFG_ADJ_MAP, {$urandom, $urandom});
      end
      3: begin
        cfg_write(ptc_pkg::CFG_NUM_PARTS, 64'($urandom_range(8, 2)));
        cfg_write(ptc_pkg::CFG_NODE_COUNT, 64'd4096);
        cfg_write(ptc_pkg::CFG_ADJ_MAP, '0);
      end
      4: begin
        cfg_write(ptc_pkg::CFG_NUM_PARTS, 64'($urandom_range(15)));
        cfg_write(ptc_pkg::CFG_NODE_COUNT, 64'd128);
        cfg_write(ptc_pkg::CFG_ADJ_MAP, {$urandom, $urandom});
      end
      5: begin
        cfg_write(ptc_pkg::CFG_NUM_PARTS, 64'd8);
        cfg_write(ptc_pkg::CFG_NODE_COUNT, 64'd8191);
      end
      6: begin
        cfg_write(ptc_pkg::CFG_NUM_PARTS, 64'd3);
        cfg_write(ptc_pkg::CFG_NODE_COUNT, 64'd1);
        cfg_write(ptc_pkg::CFG_ADJ_MAP, {$urandom, $urandom});
      end
      default: begin
        cfg_write(ptc_pkg::CFG_NUM_PARTS, 64'd8);
        cfg_write(ptc_pkg::CFG_NODE_COUNT, 64'd4096);
        cfg_write(ptc_pkg::CFG_ADJ_MAP, {$urandom, $urandom});
      end
    endcase
    case (ph % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 52; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 52; end
      default: begin gap_pct = 18; stall_pct = 18; end
    endcase
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check_beat
    counts_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tally_q.size() == 0) begin
        flag_mismatch($sformatf("output beat with nothing pending: %h", out_tdata));
      end else begin
        want = tally_q.pop_front();
        if (out_tdata[31:0] !== want.cut)
          flag_mismatch($sformatf("cut_count %0d, predicted %0d", out_tdata[31:0], want.cut));
        if (out_tdata[63:32] !== want.viol)
          flag_mismatch($sformatf("violation_count %0d, predicted %0d", out_tdata[63:32],
                                  want.viol));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    err_count     = 0;
    stuck_cycles  = 0;
    gap_pct       = 0;
    stall_pct     = 0;
    phase_items   = 0;
    drained_once  = 1'b0;
    anchor_part_q = '0;
    anchor_ok     = 1'b0;
    cut_cnt       = '0;
    viol_cnt      = '0;
    k_reg         = ptc_pkg::NUM_PARTS_RST;
    nodes_reg     = ptc_pkg::NODE_COUNT_RST;
    adj_reg       = ptc_pkg::ADJ_MAP_RST;
    for (int i = 0; i < ptc_pkg::MAX_NODES_DEF; i++) begin
      part_tbl[i]   = '0;
      loaded_map[i] = 1'b0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].is_cfg)
        cfg_write(PLAN[i].reg_sel, PLAN[i].reg_val);
      else
        push_item(PLAN[i].op, PLAN[i].node, PLAN[i].part, PLAN[i].first, PLAN[i].typed,
                  '{cut: PLAN[i].cut, viol: PLAN[i].viol});
    end

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      program_phase(ph);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        int r;
        r = $urandom_range(99);
        if (r < 20) send_loads();
        else if (r < 82) send_net();
        else send_noise();
        // hold input until the pipeline is empty, once mid-run
        if (ph == 3 && !drained_once && phase_items >= ITEMS_PER_PHASE / 2) begin
          in_tvalid <= 1'b0;
          wait_drained();
          drained_once = 1'b1;
        end
      end
    end

    in_tvalid <= 1'b0;
    cfg_we    <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/ptc_pkg.sv
hdl/ptc_table.sv
hdl/ptc_score.sv
hdl/partition_cut_and_violation_counter.sv
sim/partition_cut_and_violation_counter_tb.sv
